@@ sv/mset_pkg.sv @@
// mset_pkg: shared types and command codes for the multi-slot event timer
// no dependencies; imported by the slot cell, the top level and the checker
`timescale 1ns / 1ps

package mset_pkg;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_CONFIGURE = 2'd1,
        CMD_ENABLE    = 2'd2,
        CMD_DISABLE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [31:0] now;
        logic [31:0] interval;
        logic        oneshot;
        logic        fixed_rate;
    } t_in_beat;

    typedef struct packed {
        logic       fired;
        logic [3:0] fired_slot;
        logic       slot_enabled;
        logic       last;
    } t_out_beat;

    // broadcast from the top level to every slot cell
    typedef struct packed {
        logic        start;     // tick accepted: latch due flags, load token
        logic        step;      // token advances one cell
        logic        wr_cfg;
        logic        wr_en;
        logic        wr_dis;
        logic [3:0]  slot;
        logic [31:0] now;
        logic [31:0] interval;
        logic        oneshot;
        logic        fixed_rate;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

endpackage

@@ sv/multi_slot_event_timer.sv @@
// multi_slot_event_timer: command-driven table of timer slots, one cell per slot
// slot commands: configure/enable/disable give their beat in the cycle after acceptance
// tick: a token walks the cell chain one slot per cycle while the output is not stalled;
//   the last beat leaves from the flush state once the walk has passed the final slot
// input: one item at a time; a tick keeps the input stalled through its walk and flush,
//   a slot command leaves the block idle, and a stalled output stalls the input too
// reset: synchronous active-low, clears all slots to disabled with zero times
`timescale 1ns / 1ps

module multi_slot_event_timer
    import mset_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state          r_state;
    logic [IW-1:0]   r_idx;
    logic [31:0]     r_now;
    logic            r_pend_valid;
    logic [3:0]      r_pend_slot;
    logic            r_out_valid;
    t_out_beat       r_out;

    t_cell_ctl       ctl;
    logic [NUM_SLOTS-1:0] tok, fire;
    logic            out_free, accept, fire_any, step, slot_ok, walk_end, emit;
    logic [6:0]      idx_w;
    logic [3:0]      idx4;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && (r_state == S_IDLE) && out_free;
    assign step     = (r_state == S_WALK) && out_free;
    assign fire_any = |fire;
    assign idx_w    = 7'(r_idx);
    assign idx4     = idx_w[3:0];
    assign walk_end = (r_idx == IW'(NUM_SLOTS - 1));
    assign slot_ok  = ({3'b000, i_in.slot} < 7'(NUM_SLOTS));
    // a new output beat is loaded this cycle
    assign emit     = (accept && (i_in.command != CMD_TICK)) ||
                      (step && fire_any && r_pend_valid) ||
                      ((r_state == S_FLUSH) && out_free);

    always_comb begin
        ctl            = '0;
        ctl.start      = accept && (i_in.command == CMD_TICK);
        ctl.step       = step;
        ctl.wr_cfg     = accept && (i_in.command == CMD_CONFIGURE);
        ctl.wr_en      = accept && (i_in.command == CMD_ENABLE);
        ctl.wr_dis     = accept && (i_in.command == CMD_DISABLE);
        ctl.slot       = i_in.slot;
        ctl.now        = (r_state == S_IDLE) ? i_in.now : r_now;
        ctl.interval   = i_in.interval;
        ctl.oneshot    = i_in.oneshot;
        ctl.fixed_rate = i_in.fixed_rate;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        logic tok_in;
        if (g == 0) begin : g_head
            assign tok_in = 1'b0;
        end else begin : g_link
            assign tok_in = tok[g-1];
        end
        mset_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   (tok_in),
            .o_tok   (tok[g]),
            .o_fire  (fire[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in.command == CMD_TICK) begin
                            r_state      <= S_WALK;
                            r_idx        <= '0;
                            r_now        <= i_in.now;
                            r_pend_valid <= 1'b0;
                        end else begin
                            r_out.fired        <= 1'b0;
                            r_out.fired_slot   <= '0;
                            r_out.slot_enabled <= slot_ok &&
                                                  (i_in.command == CMD_ENABLE);
                            r_out.last         <= 1'b1;
                        end
                    end
                end
                S_WALK: begin
                    if (step) begin
                        // hold one fired slot back so the final one can carry last
                        if (fire_any) begin
                            if (r_pend_valid) begin
                                r_out.fired        <= 1'b1;
                                r_out.fired_slot   <= r_pend_slot;
                                r_out.slot_enabled <= 1'b0;
                                r_out.last         <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_slot  <= idx4;
                        end
                        r_idx <= r_idx + 1'b1;
                        if (walk_end) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out.fired        <= r_pend_valid;
                        r_out.fired_slot   <= r_pend_valid ? r_pend_slot : 4'd0;
                        r_out.slot_enabled <= 1'b0;
                        r_out.last         <= 1'b1;
                        r_pend_valid       <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/mset_cell.sv @@
// mset_cell: one timer slot with its flags, period, due time and walk token
// depends on mset_pkg; chained by multi_slot_event_timer
`timescale 1ns / 1ps

module mset_cell
    import mset_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_tok,
    output logic      o_tok,
    output logic      o_fire
);

    localparam bit         ADDRESSABLE = (IDX < 16);
    localparam logic [3:0] ID4         = 4'(IDX);

    logic        r_en, r_os, r_fr, r_hit, r_tok;
    logic [31:0] r_period, r_due;
    logic        sel;
    logic        fire;

    assign sel  = ADDRESSABLE && (i_ctl.slot == ID4);
    assign fire = r_tok && r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_os     <= 1'b0;
            r_fr     <= 1'b0;
            r_hit    <= 1'b0;
            r_tok    <= 1'b0;
            r_period <= '0;
            r_due    <= '0;
        end else begin
            if (i_ctl.start) begin
                r_hit <= r_en && !(r_due > i_ctl.now);
                r_tok <= (IDX == 0);
            end else if (i_ctl.step) begin
                r_tok <= i_tok;
            end

            if (i_ctl.step && fire) begin
                if (r_os) begin
                    r_en <= 1'b0;
                end else if (r_fr) begin
                    r_due <= r_due + r_period;
                end else begin
                    r_due <= i_ctl.now + r_period;
                end
            end

            if (sel && i_ctl.wr_cfg) begin
                r_period <= i_ctl.interval;
                r_os     <= i_ctl.oneshot;
                r_fr     <= i_ctl.fixed_rate;
                r_en     <= 1'b0;
            end else if (sel && i_ctl.wr_en) begin
                r_due <= i_ctl.now + r_period;
                r_en  <= 1'b1;
            end else if (sel && i_ctl.wr_dis) begin
                r_en <= 1'b0;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_fire = fire;

endmodule

@@ sv/mset_checker.sv @@
// mset_checker: port-level assertions for multi_slot_event_timer
// depends on mset_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module mset_checker
    import mset_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output beat changed");

    // a slot command answers with a single last beat on the next cycle
    a_cmd_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.command != CMD_TICK)
        |=> o_out_valid && o_out.last && !o_out.fired)
        else $error("slot command reply missing or malformed");

    // a disable always reports the slot as off
    a_dis_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.command == CMD_DISABLE)
        |=> !o_out.slot_enabled)
        else $error("disabled slot reported enabled");

    // only fired-slot beats of a tick may be non-final
    a_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.fired && !o_out.slot_enabled)
        else $error("non-final beat is not a fired slot");

endmodule

bind multi_slot_event_timer mset_checker u_mset_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
